// ----- src/weighted_moving_average_assert.svh -----
// ----------------------------------------------------------------------------
// weighted_moving_average_assert.svh
// Assertion macros for the weighted moving average block.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MOVING_AVERAGE_ASSERT_SVH
`define WEIGHTED_MOVING_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS
// Check that expr holds at every edge outside reset.
`define WMA_ASSERT(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("wma assertion failed");
// Check that cons holds in the cycle after ante.
`define WMA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wma assertion failed");
`else
`define WMA_ASSERT(name, clk, rst, expr)
`define WMA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- src/wma_pkg.sv -----
// ----------------------------------------------------------------------------
// wma_pkg
// Shared constants and types of the weighted moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

  localparam int PERIOD_BITS     = 6;
  localparam int PERIOD_RESET    = 12;
  localparam int DEF_MAX_PERIOD  = 32;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int ROUND_SCALE     = 10;
  localparam int ROUND_HALF      = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_SCALED,
    ST_ROUND_START,
    ST_ROUND,
    ST_OUT
  } back_state_t;

endpackage

// ----- src/weighted_moving_average.sv -----
// ----------------------------------------------------------------------------
// weighted_moving_average
// Linearly weighted moving average over the last period samples, rounded.
// ----------------------------------------------------------------------------
// The input side takes one sample a cycle into a two-entry queue while the
// queue has room. The engine stores each sample; a sample that yields an
// average then walks the window through the single read port of the sample
// RAM, is divided serially by the weight total (one quotient bit a cycle),
// with DW = SAMPLE_BITS + clog2(MAX_PERIOD*(MAX_PERIOD+1)/2 + 1) + 4, and is
// rounded, the division by ten being a reciprocal multiply. The average is
// shown until taken. The sample store needs no clearing after reset.
// ----------------------------------------------------------------------------
module weighted_moving_average #(
  parameter int MAX_PERIOD  = wma_pkg::DEF_MAX_PERIOD,
  parameter int SAMPLE_BITS = wma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [wma_pkg::PERIOD_BITS-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   average
);

  `include "weighted_moving_average_assert.svh"

  localparam int NW   = $clog2(MAX_PERIOD + 1);
  localparam int WMAX = MAX_PERIOD * (MAX_PERIOD + 1) / 2;
  localparam int WW   = $clog2(WMAX + 1);
  localparam int EW   = SAMPLE_BITS + 1 + NW + WW;

  logic                   push;
  logic [SAMPLE_BITS-1:0] push_sample;
  logic                   push_emit;
  logic [NW-1:0]          push_n;
  logic [WW-1:0]          push_wsum;
  logic                   pop;
  logic                   q_full;
  logic                   q_empty;
  logic [EW-1:0]          q_rdata;

  wma_front #(
    .MAX_PERIOD (MAX_PERIOD),
    .SAMPLE_BITS(SAMPLE_BITS),
    .NW         (NW),
    .WW         (WW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .restart    (restart),
    .q_full     (q_full),
    .push       (push),
    .push_sample(push_sample),
    .push_emit  (push_emit),
    .push_n     (push_n),
    .push_wsum  (push_wsum)
  );

  wma_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({push_sample, push_emit, push_n, push_wsum}),
    .pop  (pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  wma_back #(
    .MAX_PERIOD (MAX_PERIOD),
    .SAMPLE_BITS(SAMPLE_BITS),
    .NW         (NW),
    .WW         (WW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_sample (q_rdata[EW-1 -: SAMPLE_BITS]),
    .q_emit   (q_rdata[NW+WW]),
    .q_n      (q_rdata[NW+WW-1 -: NW]),
    .q_wsum   (q_rdata[WW-1:0]),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .average  (average)
  );

  `WMA_ASSERT(a_no_push_when_full, clk, rst, !(push && q_full))
  `WMA_ASSERT(a_no_pop_when_empty, clk, rst, !(pop && q_empty))
  `WMA_ASSERT(a_no_pop_while_result, clk, rst, !(pop && out_valid))
  `WMA_ASSERT_NEXT(a_taken_result_clears, clk, rst, out_valid && out_ready, !out_valid)

endmodule

// ----- src/wma_ram.sv -----
// ----------------------------------------------------------------------------
// wma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/wma_div.sv -----
// ----------------------------------------------------------------------------
// wma_div
// Signed by positive divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module wma_div #(
  parameter int DW = 38,
  parameter int VW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] qm;
  logic          neg;
  logic [VW:0]   trial;
  logic          fits;

  // Shift in the next dividend bit and try one subtract.
  assign trial    = {rem, qm[DW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = neg ? -$signed(qm) : $signed(qm);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(DW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qm  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      neg <= dividend[DW-1];
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      rem <= fits ? VW'(trial - {1'b0, dvs}) : VW'(trial);
      qm  <= {qm[DW-2:0], fits};
    end
  end

endmodule

// ----- src/wma_front.sv -----
// ----------------------------------------------------------------------------
// wma_front
// Input side: holds the period register and the series fill count, and
// decides for every accepted sample whether it yields an average.
// ----------------------------------------------------------------------------
module wma_front #(
  parameter int MAX_PERIOD  = 32,
  parameter int SAMPLE_BITS = 24,
  parameter int NW          = 6,
  parameter int WW          = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wma_pkg::PERIOD_BITS-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic                             restart,
  input  logic                             q_full,
  output logic                             push,
  output logic [SAMPLE_BITS-1:0]           push_sample,
  output logic                             push_emit,
  output logic [NW-1:0]                    push_n,
  output logic [WW-1:0]                    push_wsum
);

  import wma_pkg::*;

  localparam logic [9:0] MAXV = 10'(MAX_PERIOD);

  logic [PERIOD_BITS-1:0] period;
  logic [NW-1:0]          fill_count;
  logic [NW-1:0]          fill_base;
  logic [NW-1:0]          fill_count_next;
  logic [NW-1:0]          n;
  logic [2*NW-1:0]        nn;

  // Zero acts as one, anything above the store depth saturates.
  always_comb begin
    if (period == '0) begin
      n = NW'(1);
    end else if (10'(period) > MAXV) begin
      n = NW'(MAX_PERIOD);
    end else begin
      n = NW'(period);
    end
  end

  assign nn = (2*NW)'(n) * ((2*NW)'(n) + 1'b1);

  assign fill_base       = restart ? '0 : fill_count;
  assign fill_count_next = (fill_base < NW'(MAX_PERIOD)) ? fill_base + 1'b1 : fill_base;

  assign in_ready    = !q_full;
  assign push        = in_valid && in_ready;
  assign push_sample = sample;
  assign push_emit   = fill_count_next >= n;
  assign push_n      = n;
  assign push_wsum   = WW'(nn >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_BITS'(PERIOD_RESET);
      fill_count <= '0;
    end else begin
      if (cfg_write) begin
        period <= cfg_data;
      end
      if (push) begin
        fill_count <= fill_count_next;
      end
    end
  end

endmodule

// ----- src/wma_queue.sv -----
// ----------------------------------------------------------------------------
// wma_queue
// Two-entry queue between the input side and the averaging engine.
// ----------------------------------------------------------------------------
module wma_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = count == 2'(DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- src/wma_back.sv -----
// ----------------------------------------------------------------------------
// wma_back
// Averaging engine: stores each sample, walks the window newest to oldest
// with a multiply-accumulate, divides by the weight total serially, then
// rounds with a reciprocal multiply.
// ----------------------------------------------------------------------------
module wma_back #(
  parameter int MAX_PERIOD  = 32,
  parameter int SAMPLE_BITS = 24,
  parameter int NW          = 6,
  parameter int WW          = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [SAMPLE_BITS-1:0]        q_sample,
  input  logic                          q_emit,
  input  logic [NW-1:0]                 q_n,
  input  logic [WW-1:0]                 q_wsum,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] average
);

  import wma_pkg::*;

  localparam int AW = $clog2(MAX_PERIOD);
  localparam int PW = SAMPLE_BITS + NW + 1;
  localparam int SW = SAMPLE_BITS + WW;
  localparam int DW = SW + 4;
  // |q + 5| stays below 2**RN; the reciprocal is exact for that range.
  localparam int RN = SAMPLE_BITS + 3;
  localparam int RS = RN + $clog2(ROUND_SCALE);
  localparam logic [RN:0] RECIP =
    (RN+1)'(((64'd1 << RS) + 64'(ROUND_SCALE - 1)) / 64'(ROUND_SCALE));

  back_state_t state;
  back_state_t state_next;

  logic [AW-1:0]          wp;
  logic [AW-1:0]          rd_slot;
  logic [NW-1:0]          issue_w;
  logic [NW-1:0]          w1;
  logic                   v1;
  logic                   v2;
  logic signed [PW-1:0]   prod;
  logic signed [SW-1:0]   acc;
  logic [WW-1:0]          wsum;
  logic signed [DW-1:0]   qr;
  logic [SAMPLE_BITS-1:0] avg;
  logic [2*RN:0]          rprod;
  logic                   rneg;

  logic                   issue;
  logic                   div_start;
  logic                   div_done;
  logic signed [DW-1:0]   div_quo;
  logic signed [DW-1:0]   acc_x;
  logic signed [DW-1:0]   scaled;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [RN-1:0]          qr_mag;
  logic [RN-1:0]          rquo;

  wma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_PERIOD)
  ) u_store (
    .clk  (clk),
    .we   (pop),
    .waddr(wp),
    .wdata(q_sample),
    .raddr(rd_slot),
    .rdata(rdata)
  );

  wma_div #(
    .DW(DW),
    .VW(WW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(scaled),
    .divisor (wsum),
    .done    (div_done),
    .quotient(div_quo)
  );

  // 10 * S as two shifts and an add.
  assign acc_x  = DW'(acc);
  assign scaled = (acc_x <<< 3) + (acc_x <<< 1);

  assign qr_mag  = qr[DW-1] ? RN'(-qr) : RN'(qr);
  assign rquo    = RN'(rprod >> RS);
  assign average = $signed(avg);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty && q_emit) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue_w == NW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_DIV_SCALED;
        end
      end
      ST_DIV_SCALED: begin
        if (div_done) begin
          state_next = ST_ROUND_START;
        end
      end
      ST_ROUND_START: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:        pop       = !q_empty;
      ST_WALK:        issue     = issue_w != '0;
      ST_DRAIN:       div_start = !v1 && !v2;
      ST_DIV_SCALED:  ;
      ST_ROUND_START: ;
      ST_ROUND:       ;
      ST_OUT:         out_valid = 1'b1;
      default:        ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      // Advance the write slot on every stored beat, wrapping at the depth.
      if (pop) begin
        wp <= (wp == AW'(MAX_PERIOD - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_emit) begin
      rd_slot <= wp;
      issue_w <= q_n;
      wsum    <= q_wsum;
      acc     <= '0;
    end else begin
      if (issue) begin
        rd_slot <= (rd_slot == '0) ? AW'(MAX_PERIOD - 1) : rd_slot - 1'b1;
        issue_w <= issue_w - 1'b1;
      end
      if (v2) begin
        acc <= acc + SW'(prod);
      end
    end
    w1   <= issue_w;
    prod <= $signed(rdata) * $signed({1'b0, w1});
    if (state == ST_DIV_SCALED && div_done) begin
      qr <= div_quo + DW'(ROUND_HALF);
    end
    // Divide q + 5 by ten on the magnitude, truncating toward zero.
    if (state == ST_ROUND_START) begin
      rprod <= (2*RN+1)'(qr_mag) * (2*RN+1)'(RECIP);
      rneg  <= qr[DW-1];
    end
    if (state == ST_ROUND) begin
      avg <= rneg ? SAMPLE_BITS'(-rquo) : SAMPLE_BITS'(rquo);
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weighted moving average block. A local model
// of the sample window predicts every rounded average. Each accepted input
// beat updates that model, and each output beat is checked in order against
// the oldest predicted average. The run drives directed cases, output
// backpressure and three random phases with different idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW            = wma_pkg::DEF_SAMPLE_BITS;
  localparam int PB            = wma_pkg::PERIOD_BITS;
  localparam int WIN_DEPTH     = wma_pkg::DEF_MAX_PERIOD;
  localparam int SETTLE_CYCLES = 300;
  localparam int REPORT_LIMIT  = 10;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cfg_write = 1'b0;
  logic [PB-1:0] cfg_data  = '0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  logic signed [SW-1:0] sample = '0;
  logic          restart   = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic signed [SW-1:0] average;

  // Window model of the block.
  logic signed [SW-1:0] window_copy [WIN_DEPTH];
  logic [4:0]           next_slot   = '0;
  logic [5:0]           series_fill = '0;
  logic [PB-1:0]        period_setting = PB'(wma_pkg::PERIOD_RESET);

  logic signed [SW-1:0] expected_averages [$];
  logic signed [SW-1:0] oldest_average;
  int fail_count  = 0;
  int tx_idle_pct = 10;
  int rx_idle_pct = 62;
  int hold_cycles = 0;

  weighted_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .average   (average)
  );

  always #4 clk = ~clk;

  initial begin
    #6_000_000;
    $display("Verification failed");
    $finish;
  end

  // Push one sample into the window model; return 1 when it yields an average.
  function automatic bit update_window_average(input logic signed [SW-1:0] value,
                                               input logic new_series,
                                               output logic signed [SW-1:0] avg);
    longint wsum;
    longint wtotal;
    longint scaled;
    longint rounded;
    int     taps;
    int     slot;
    wsum   = 0;
    wtotal = 0;
    if (new_series) begin
      series_fill = '0;
      next_slot   = '0;
    end
    window_copy[next_slot] = value;
    next_slot = next_slot + 5'd1;
    if (series_fill < WIN_DEPTH) series_fill = series_fill + 6'd1;
    if (period_setting == 0) taps = 1;
    else if (period_setting > WIN_DEPTH) taps = WIN_DEPTH;
    else taps = period_setting;
    avg = '0;
    if (series_fill < taps) return 1'b0;
    // Newest sample carries weight taps, oldest weight 1.
    slot = next_slot;
    for (int k = 0; k < taps; k++) begin
      slot    = (slot == 0) ? WIN_DEPTH - 1 : slot - 1;
      wsum   += longint'(window_copy[slot]) * longint'(taps - k);
      wtotal += longint'(taps - k);
    end
    scaled  = (wsum * wma_pkg::ROUND_SCALE) / wtotal;
    rounded = (scaled + wma_pkg::ROUND_HALF) / wma_pkg::ROUND_SCALE;
    avg = rounded[SW-1:0];
    return 1'b1;
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SW'($signed($urandom_range(40)) - 20);
      3: return SAMPLE_MAX - SW'($urandom_range(15));
      4: return SAMPLE_MIN + SW'($urandom_range(15));
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic signed [SW-1:0] value, input logic new_series);
    logic signed [SW-1:0] avg;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    restart  <= new_series;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (update_window_average(value, new_series, avg))
      expected_averages = {expected_averages, avg};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  // Write only with the engine idle: drain, then let any no-result beat finish.
  task automatic write_period(input logic [PB-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    period_setting = value;
  endtask

  task automatic test_period_one_extremes();
    write_period(PB'(1));
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MIN, 1'b0);
    send_item('0, 1'b0);
    send_item(-SW'(1), 1'b0);
    send_item(SW'(1), 1'b0);
  endtask

  task automatic test_negative_rounding();
    write_period(PB'(3));
    send_item(-SW'(1), 1'b1);
    send_item(-SW'(1), 1'b0);
    send_item('0, 1'b0);
    send_item(-SW'(2), 1'b0);
    // Cut the series short; no average until three new samples are in.
    send_item(SW'(1), 1'b1);
    send_item(-SW'(3), 1'b0);
  endtask

  task automatic test_period_zero();
    write_period('0);
    send_item(SW'(7), 1'b1);
    send_item(-SW'(7), 1'b0);
  endtask

  task automatic test_period_change_mid_series();
    write_period(PB'(4));
    send_item(SW'(100), 1'b1);
    send_item(-SW'(250), 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SW'(3), 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    // Widen past the fill level, then narrow over the same stored samples.
    write_period(PB'(6));
    send_item(SW'(42), 1'b0);
    write_period(PB'(2));
    send_item(-SW'(9), 1'b0);
    send_item(SW'(5), 1'b0);
  endtask

  task automatic test_output_backpressure();
    write_period(PB'(2));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 800;
    send_item(random_sample(), 1'b1);
    for (int k = 0; k < 13; k++) send_item(random_sample(), 1'b0);
    drain_results();
  endtask

  task automatic run_random_phase(input int item_total, input int tx_pct, input int rx_pct);
    int sent;
    int seg_len;
    int burst;
    logic [PB-1:0] per;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < item_total) begin
      case ($urandom_range(7))
        0: per = '0;
        1: per = PB'(1);
        2: per = PB'(WIN_DEPTH);
        3: per = '1;
        4: per = PB'(WIN_DEPTH + 1);
        default: per = PB'($urandom_range(2, WIN_DEPTH - 1));
      endcase
      write_period(per);
      seg_len = $urandom_range(60, 160);
      send_item(random_sample(), 1'b1);
      for (int k = 1; k < seg_len; k++) begin
        if ($urandom_range(99) == 0) begin
          // Broken series: a run of restarts that fills no window wider than one sample.
          burst = $urandom_range(1, 4);
          for (int b = 0; b < burst; b++) send_item(random_sample(), 1'b1);
        end
        send_item(random_sample(), $urandom_range(199) < 3);
        if ($urandom_range(199) == 0) drain_results();
      end
      sent += seg_len;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected average %0d at %0t", average, $realtime);
      end else begin
        oldest_average = expected_averages.pop_front();
        if (average !== oldest_average) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("average mismatch at %0t: expected %0d, got %0d",
                     $realtime, oldest_average, average);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_period_one_extremes();
    test_negative_rounding();
    test_period_zero();
    test_period_change_mid_series();
    test_output_backpressure();
    run_random_phase(300, 10, 62);
    run_random_phase(300, 62, 10);
    run_random_phase(300, 0, 0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_averages.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
